### hdl/pwec_pkg.sv
`default_nettype none

package pwec_pkg;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_NOT_PRES = 3'd1;
    localparam logic [2:0] STATUS_RSV_BIT  = 3'd2;
    localparam logic [2:0] STATUS_NO_ACC   = 3'd3;
    localparam logic [2:0] STATUS_NO_EXEC  = 3'd4;

    localparam logic [2:0] REG_WRITE_PROTECT  = 3'd0;
    localparam logic [2:0] REG_PAGE_SIZE_EXT  = 3'd1;
    localparam logic [2:0] REG_PHYS_ADDR_EXT  = 3'd2;
    localparam logic [2:0] REG_LONG_MODE      = 3'd3;
    localparam logic [2:0] REG_NO_EXEC_ENABLE = 3'd4;
    localparam logic [2:0] REG_PHYS_ADDR_BITS = 3'd5;

    localparam int unsigned ENTRY_W    = 64;
    localparam int unsigned LEVEL_W    = 3;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 6;

    localparam int unsigned BIT_P  = 0;
    localparam int unsigned BIT_RW = 1;
    localparam int unsigned BIT_US = 2;
    localparam int unsigned BIT_A  = 5;
    localparam int unsigned BIT_D  = 6;
    localparam int unsigned BIT_PS = 7;
    localparam int unsigned BIT_NX = 63;

    localparam logic [5:0] PHYS_BITS_RESET = 6'd36;
    localparam logic [5:0] PHYS_BITS_MIN   = 6'd32;
    localparam logic [5:0] PHYS_BITS_MAX   = 6'd52;
    localparam logic [63:0] BASE_FRAME_MASK = 64'h0000_000F_FFFF_F000;

    localparam logic [1:0] DEPTH_TWO   = 2'd0;
    localparam logic [1:0] DEPTH_THREE = 2'd1;
    localparam logic [1:0] DEPTH_FOUR  = 2'd2;

    localparam logic [2:0] KIND_LARGE_PDE  = 3'd0;
    localparam logic [2:0] KIND_PTE        = 3'd1;
    localparam logic [2:0] KIND_PDE        = 3'd2;
    localparam logic [2:0] KIND_PDPE       = 3'd3;
    localparam logic [2:0] KIND_PML4E      = 3'd4;
    localparam logic [2:0] KIND_LARGE_PDPE = 3'd5;

    typedef struct packed {
        logic        write_protect;
        logic        page_size_ext;
        logic        phys_addr_ext;
        logic        long_mode;
        logic        no_exec_enable;
        logic [63:0] frame_toggle;
    } cfg_t;

    typedef struct packed {
        logic [63:0] table_entry;
        logic [2:0]  walk_level;
        logic        write_access;
        logic        user_access;
        logic        exec_access;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] entry_out;
        logic        write_back;
        logic        is_leaf;
    } result_t;

    // Frame bits between the nominal 36-bit width and the configured width.
    function automatic logic [63:0] frame_toggle(input logic [5:0] pb);
        logic [5:0]  pbc;
        logic [63:0] fm;
        pbc = pb;
        if (pbc < PHYS_BITS_MIN)
        begin
            pbc = PHYS_BITS_MIN;
        end
        if (pbc > PHYS_BITS_MAX)
        begin
            pbc = PHYS_BITS_MAX;
        end
        for (int i = 0; i < 64; i++)
        begin
            fm[i] = (i >= 12) && (i < int'(pbc));
        end
        return fm ^ BASE_FRAME_MASK;
    endfunction

    function automatic logic [63:0] rsv_mask(input logic       nxe,
                                             input logic [1:0] dsel,
                                             input logic [2:0] kind);
        logic [63:0] mask;
        mask = 64'hFFFF_FFFF_FFFF_FFFF;
        case (dsel)
            DEPTH_TWO:
            begin
                case (kind)
                    KIND_LARGE_PDE: mask = 64'h0000_0000_0020_0000;
                    KIND_PTE:       mask = 64'h0000_0000_0000_0000;
                    KIND_PDE:       mask = 64'h0000_0000_0000_0000;
                    default:        mask = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
            end
            DEPTH_THREE:
            begin
                case (kind)
                    KIND_LARGE_PDE: mask = 64'hFFFF_FFF0_001F_E000;
                    KIND_PTE:       mask = 64'hFFFF_FFF0_0000_0000;
                    KIND_PDE:       mask = 64'hFFFF_FFF0_0000_0000;
                    KIND_PDPE:      mask = 64'hFFFF_FFF0_0000_01E6;
                    default:        mask = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
                if (nxe && (kind == KIND_LARGE_PDE || kind == KIND_PTE ||
                            kind == KIND_PDE))
                begin
                    mask[BIT_NX] = 1'b0;
                end
            end
            DEPTH_FOUR:
            begin
                case (kind)
                    KIND_LARGE_PDE:  mask = 64'h800F_FFF0_001F_E000;
                    KIND_PTE:        mask = 64'h800F_FFF0_0000_0000;
                    KIND_PDE:        mask = 64'h800F_FFF0_0000_0000;
                    KIND_PDPE:       mask = 64'h800F_FFF0_0000_0100;
                    KIND_PML4E:      mask = 64'h800F_FFF0_0000_0180;
                    KIND_LARGE_PDPE: mask = 64'h800F_FFF0_3FFF_E000;
                    default:         mask = 64'hFFFF_FFFF_FFFF_FFFF;
                endcase
                if (nxe)
                begin
                    mask[BIT_NX] = 1'b0;
                end
            end
            default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

### hdl/page_walk_entry_checker.sv
// Channel  | Handshake         | Payload
// ---------+-------------------+------------------------------------------------
// in       | in_valid/in_stall | table_entry walk_level write_access
//          |                   | user_access exec_access
// out      | out_valid/out_stall| status entry_out write_back is_leaf
// cfg      | cfg_write         | cfg_index cfg_data
//
// An item is registered on input, checked by combinational logic, and
// registered again as the result, which is held in the output register
// until it is taken. One item is accepted every cycle while the output is
// taken. The input stage refills while a result waits, so in_stall rises
// only when both stages are full and out_stall is high. Reset clears both
// stages and returns the configuration registers to their reset values.
`default_nettype none

module page_walk_entry_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [63:0]                    table_entry,
    input  wire logic [2:0]                     walk_level,
    input  wire logic                           write_access,
    input  wire logic                           user_access,
    input  wire logic                           exec_access,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [2:0]                          status,
    output logic [63:0]                         entry_out,
    output logic                                write_back,
    output logic                                is_leaf,
    input  wire logic                           cfg_write,
    input  wire logic [pwec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwec_pkg::CFG_DATA_W-1:0] cfg_data
);

    pwec_pkg::cfg_t    cfg;
    pwec_pkg::req_t    s1_req_reg;
    pwec_pkg::result_t res;
    pwec_pkg::result_t out_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              s1_free;
    logic              in_take;

    pwec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwec_check u_check (
        .cfg (cfg),
        .req (s1_req_reg),
        .res (res)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        s1_free        = !s1_valid_reg || out_free;
        in_take        = in_valid && s1_free;
        s1_valid_next  = in_take || (s1_valid_reg && !out_free);
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg.table_entry  <= table_entry;
            s1_req_reg.walk_level   <= walk_level;
            s1_req_reg.write_access <= write_access;
            s1_req_reg.user_access  <= user_access;
            s1_req_reg.exec_access  <= exec_access;
        end
        if (out_free && s1_valid_reg)
        begin
            out_reg <= res;
        end
    end

    assign in_stall   = !s1_free;
    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign entry_out  = out_reg.entry_out;
    assign write_back = out_reg.write_back;
    assign is_leaf    = out_reg.is_leaf;

endmodule

`default_nettype wire

### hdl/pwec_cfg.sv
`default_nettype none

module pwec_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [pwec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwec_pkg::CFG_DATA_W-1:0] cfg_data,
    output pwec_pkg::cfg_t                      cfg
);

    pwec_pkg::cfg_t cfg_reg;
    pwec_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pwec_pkg::REG_WRITE_PROTECT:  cfg_next.write_protect  = cfg_data[0];
                pwec_pkg::REG_PAGE_SIZE_EXT:  cfg_next.page_size_ext  = cfg_data[0];
                pwec_pkg::REG_PHYS_ADDR_EXT:  cfg_next.phys_addr_ext  = cfg_data[0];
                pwec_pkg::REG_LONG_MODE:      cfg_next.long_mode      = cfg_data[0];
                pwec_pkg::REG_NO_EXEC_ENABLE: cfg_next.no_exec_enable = cfg_data[0];
                pwec_pkg::REG_PHYS_ADDR_BITS:
                    cfg_next.frame_toggle = pwec_pkg::frame_toggle(cfg_data);
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.write_protect  <= 1'b0;
            cfg_reg.page_size_ext  <= 1'b0;
            cfg_reg.phys_addr_ext  <= 1'b0;
            cfg_reg.long_mode      <= 1'b0;
            cfg_reg.no_exec_enable <= 1'b0;
            cfg_reg.frame_toggle   <= pwec_pkg::frame_toggle(pwec_pkg::PHYS_BITS_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hdl/pwec_check.sv
`default_nettype none

module pwec_check (
    input  wire pwec_pkg::cfg_t cfg,
    input  wire pwec_pkg::req_t req,
    output pwec_pkg::result_t   res
);

    logic        pae;
    logic        pse;
    logic [1:0]  dsel;
    logic [2:0]  kind;
    logic [63:0] mask;
    logic [63:0] e;
    logic [2:0]  status;
    logic        leaf;
    logic        wb;
    logic        lvl_ok;

    always_comb
    begin
        pae    = cfg.long_mode | cfg.phys_addr_ext;
        pse    = pae | cfg.page_size_ext;
        dsel   = cfg.long_mode ? pwec_pkg::DEPTH_FOUR :
                 (cfg.phys_addr_ext ? pwec_pkg::DEPTH_THREE : pwec_pkg::DEPTH_TWO);
        lvl_ok = (req.walk_level >= 3'd1) && (req.walk_level <= 3'd4);

        kind = req.walk_level;
        if (req.walk_level == 3'd2 && req.table_entry[pwec_pkg::BIT_PS])
        begin
            kind = pwec_pkg::KIND_LARGE_PDE;
        end
        if (req.walk_level == 3'd3 && dsel == pwec_pkg::DEPTH_FOUR &&
            req.table_entry[pwec_pkg::BIT_PS])
        begin
            kind = pwec_pkg::KIND_LARGE_PDPE;
        end
        mask = pwec_pkg::rsv_mask(cfg.no_exec_enable, dsel, kind) ^ cfg.frame_toggle;

        status = pwec_pkg::STATUS_OK;
        if (!req.table_entry[pwec_pkg::BIT_P])
        begin
            status = pwec_pkg::STATUS_NOT_PRES;
        end
        else if (pse && (!lvl_ok || (req.table_entry & mask) != 64'd0))
        begin
            status = pwec_pkg::STATUS_RSV_BIT;
        end

        // A PAE PDPE has no RW, US or A bits and behaves as if all were set.
        e = req.table_entry;
        if (dsel == pwec_pkg::DEPTH_THREE && req.walk_level == 3'd3)
        begin
            e[pwec_pkg::BIT_RW] = 1'b1;
            e[pwec_pkg::BIT_US] = 1'b1;
            e[pwec_pkg::BIT_A]  = 1'b1;
        end

        if (status == pwec_pkg::STATUS_OK)
        begin
            if (!e[pwec_pkg::BIT_US] && req.user_access)
            begin
                status = pwec_pkg::STATUS_NO_ACC;
            end
            else if (!e[pwec_pkg::BIT_RW] && req.write_access &&
                     (cfg.write_protect || req.user_access))
            begin
                status = pwec_pkg::STATUS_NO_ACC;
            end
            else if (e[pwec_pkg::BIT_NX] && req.exec_access && cfg.no_exec_enable)
            begin
                status = pwec_pkg::STATUS_NO_EXEC;
            end
        end

        if (req.walk_level == 3'd2 && !pse)
        begin
            e[pwec_pkg::BIT_PS] = 1'b0;
        end
        leaf = (req.walk_level == 3'd1) ||
               ((req.walk_level == 3'd2 || req.walk_level == 3'd3) && e[pwec_pkg::BIT_PS]);
        wb = !e[pwec_pkg::BIT_A] || (leaf && req.write_access && !e[pwec_pkg::BIT_D]);
        e[pwec_pkg::BIT_A] = 1'b1;
        if (leaf && req.write_access)
        begin
            e[pwec_pkg::BIT_D] = 1'b1;
        end

        res.status = status;
        if (status == pwec_pkg::STATUS_OK)
        begin
            res.entry_out  = e;
            res.write_back = wb;
            res.is_leaf    = leaf;
        end
        else
        begin
            res.entry_out  = req.table_entry;
            res.write_back = 1'b0;
            res.is_leaf    = 1'b0;
        end
    end

endmodule

`default_nettype wire

### hdl/pwec_assert.sv
`default_nettype none

module pwec_assert (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [63:0] entry_out,
    input wire logic        write_back,
    input wire logic        is_leaf
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_out))
        else $error("result changed while stalled");

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pwec_pkg::STATUS_OK |-> !write_back && !is_leaf)
        else $error("faulting item flagged for write-back or as leaf");

    a_not_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pwec_pkg::STATUS_NOT_PRES |-> !entry_out[pwec_pkg::BIT_P])
        else $error("not-present fault on an entry with P set");

    a_accessed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pwec_pkg::STATUS_OK |->
            entry_out[pwec_pkg::BIT_A] && entry_out[pwec_pkg::BIT_P])
        else $error("successful entry without A or P set");

endmodule

bind page_walk_entry_checker pwec_assert u_pwec_assert (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .entry_out  (entry_out),
    .write_back (write_back),
    .is_leaf    (is_leaf)
);

`default_nettype wire
